### hw/rtl/pulse_width_byte_serializer_core_defines.svh
// Assertion macros for the serializer RTL.
`ifndef PULSE_WIDTH_BYTE_SERIALIZER_CORE_DEFINES_SVH
`define PULSE_WIDTH_BYTE_SERIALIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PWBS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pwbs assertion failed");
`define PWBS_ASSERT_IMPL(lbl, ante, cons) \
	`PWBS_ASSERT(lbl, clk, arst_n, (ante) |-> (cons))
`else
`define PWBS_ASSERT(lbl, clk, rst_n, prop)
`define PWBS_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

### hw/rtl/pwbs_pkg.sv
package pwbs_pkg;

	localparam int TICK_WIDTH_DEF = 16;
	localparam int MAX_SYNC_DEF   = 32;

	// configuration register indexes
	localparam logic [2:0] CfgSyncCount   = 3'd0;
	localparam logic [2:0] CfgZeroMark    = 3'd1;
	localparam logic [2:0] CfgZeroSpace   = 3'd2;
	localparam logic [2:0] CfgOneMark     = 3'd3;
	localparam logic [2:0] CfgOneSpace    = 3'd4;
	localparam logic [2:0] CfgIdleSpace   = 3'd5;
	localparam logic [2:0] CfgBitsPerChar = 3'd6;
	localparam logic [2:0] CfgFrameMode   = 3'd7;

	// reset values
	localparam logic [5:0]  RstSyncCount   = 6'd8;
	localparam logic [15:0] RstZeroMark    = 16'd100;
	localparam logic [15:0] RstZeroSpace   = 16'd100;
	localparam logic [15:0] RstOneMark     = 16'd200;
	localparam logic [15:0] RstOneSpace    = 16'd200;
	localparam logic [15:0] RstIdleSpace   = 16'd1000;
	localparam logic [3:0]  RstBitsPerChar = 4'd8;
	localparam logic [3:0]  RstFrameMode   = 4'd1;

	// parity codes in frame_mode[3:1]
	localparam logic [2:0] ParNone  = 3'd0;
	localparam logic [2:0] ParMark  = 3'd1;
	localparam logic [2:0] ParSpace = 3'd2;
	localparam logic [2:0] ParOdd   = 3'd3;
	localparam logic [2:0] ParEven  = 3'd4;

	typedef struct packed {
		logic [5:0]  sync_count;
		logic [15:0] zero_mark;
		logic [15:0] zero_space;
		logic [15:0] one_mark;
		logic [15:0] one_space;
		logic [15:0] idle_space;
		logic [3:0]  bits_per_char;
		logic [3:0]  frame_mode;
	} cfg_t;

	typedef enum logic [1:0] {
		SymZero = 2'd0,
		SymOne  = 2'd1,
		SymTerm = 2'd2,
		SymIdle = 2'd3
	} sym_kind_t;

	typedef struct packed {
		logic      valid;
		sym_kind_t kind;
		logic      last;
	} sym_t;

endpackage

### hw/rtl/pwbs_seq.sv
module pwbs_seq #(
	parameter int MAX_SYNC = pwbs_pkg::MAX_SYNC_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [7:0]     data_byte,
	input  logic           first_byte,
	input  logic           last_byte,
	input  pwbs_pkg::cfg_t cfg,
	input  logic           step,
	output logic           busy,
	output pwbs_pkg::sym_t sym
);

	localparam int SyncW = $clog2(MAX_SYNC + 1);

	typedef enum logic [6:0] {
		StIdle  = 7'b0000001,
		StSync  = 7'b0000010,
		StTerm  = 7'b0000100,
		StData  = 7'b0001000,
		StPar   = 7'b0010000,
		StEnd   = 7'b0100000,
		StClose = 7'b1000000
	} state_t;

	state_t             state_q, state_d, after_data, after_par;
	logic [7:0]         shreg_q;
	logic [2:0]         bitcnt_q;
	logic [SyncW-1:0]   sync_q;
	logic               par_q;
	logic               last_q;
	logic [2:0]         nbits_m1;
	logic [SyncW-1:0]   nsync;
	logic               msb_first;
	logic [2:0]         pcode;
	logic               has_par;
	logic               cur_bit;
	logic               par_bit;

	always_comb begin
		if (cfg.bits_per_char == 4'd0) begin
			nbits_m1 = 3'd0;
		end else if (cfg.bits_per_char > 4'd8) begin
			nbits_m1 = 3'd7;
		end else begin
			nbits_m1 = 3'(cfg.bits_per_char - 4'd1);
		end
	end

	assign nsync = (7'(cfg.sync_count) > 7'(MAX_SYNC)) ? SyncW'(MAX_SYNC)
		: SyncW'(cfg.sync_count);
	assign msb_first = cfg.frame_mode[0];
	assign pcode     = cfg.frame_mode[3:1];
	assign has_par   = (pcode == pwbs_pkg::ParMark) || (pcode == pwbs_pkg::ParSpace)
		|| (pcode == pwbs_pkg::ParOdd) || (pcode == pwbs_pkg::ParEven);

	// shared shift unit: the next data bit always sits at one end
	assign cur_bit = msb_first ? shreg_q[7] : shreg_q[0];

	always_comb begin
		unique case (pcode)
			pwbs_pkg::ParMark:  par_bit = 1'b1;
			pwbs_pkg::ParOdd:   par_bit = ~par_q;
			pwbs_pkg::ParEven:  par_bit = par_q;
			default:            par_bit = 1'b0;
		endcase
	end

	assign after_par  = last_q ? StEnd : StIdle;
	assign after_data = has_par ? StPar : after_par;
	assign busy       = (state_q != StIdle);

	always_comb begin
		state_d  = state_q;
		sym.kind = pwbs_pkg::SymZero;
		unique case (state_q)
			StIdle: begin
				state_d = StIdle;
			end
			StSync: begin
				state_d = (sync_q == SyncW'(1)) ? StTerm : StSync;
			end
			StTerm: begin
				sym.kind = pwbs_pkg::SymTerm;
				state_d  = StData;
			end
			StData: begin
				sym.kind = cur_bit ? pwbs_pkg::SymOne : pwbs_pkg::SymZero;
				state_d  = (bitcnt_q == 3'd0) ? after_data : StData;
			end
			StPar: begin
				sym.kind = par_bit ? pwbs_pkg::SymOne : pwbs_pkg::SymZero;
				state_d  = after_par;
			end
			StEnd: begin
				state_d = StClose;
			end
			StClose: begin
				sym.kind = pwbs_pkg::SymIdle;
				state_d  = StIdle;
			end
			default: begin
				state_d = StIdle;
			end
		endcase
		sym.valid = busy;
		sym.last  = (state_d == StIdle);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else if (start) begin
			if (first_byte) begin
				state_q <= (nsync != '0) ? StSync : StTerm;
			end else begin
				state_q <= StData;
			end
		end else if (busy && step) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// align so the first bit sent sits at the shift end
			shreg_q  <= msb_first ? 8'(data_byte << (3'd7 - nbits_m1)) : data_byte;
			bitcnt_q <= nbits_m1;
			sync_q   <= nsync;
			par_q    <= 1'b0;
			last_q   <= last_byte;
		end else if (busy && step) begin
			if (state_q == StSync) begin
				sync_q <= sync_q - SyncW'(1);
			end
			if (state_q == StData) begin
				shreg_q  <= msb_first ? {shreg_q[6:0], 1'b0} : {1'b0, shreg_q[7:1]};
				bitcnt_q <= bitcnt_q - 3'd1;
				par_q    <= par_q ^ cur_bit;
			end
		end
	end

endmodule

### hw/rtl/pwbs_out.sv
module pwbs_out #(
	parameter int TICK_WIDTH = pwbs_pkg::TICK_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pwbs_pkg::sym_t sym,
	input  pwbs_pkg::cfg_t cfg,
	input  logic           out_stall,
	output logic           step,
	output logic           out_valid,
	output logic [15:0]    mark_ticks,
	output logic [15:0]    space_ticks,
	output logic           last_of_run
);

	localparam logic [15:0] TickMask = (TICK_WIDTH >= 16) ? 16'hFFFF
		: 16'((64'd1 << TICK_WIDTH) - 64'd1);

	logic        valid_q;
	logic [15:0] mark_q, space_q;
	logic        last_q;
	logic [15:0] mark_d, space_d;

	always_comb begin
		unique case (sym.kind)
			pwbs_pkg::SymZero: begin
				mark_d  = cfg.zero_mark;
				space_d = cfg.zero_space;
			end
			pwbs_pkg::SymOne: begin
				mark_d  = cfg.one_mark;
				space_d = cfg.one_space;
			end
			pwbs_pkg::SymTerm: begin
				mark_d  = cfg.zero_space;
				space_d = cfg.one_mark;
			end
			default: begin
				mark_d  = 16'd0;
				space_d = cfg.idle_space;
			end
		endcase
	end

	// advance whenever the slot is empty or being emptied
	assign step = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= sym.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && sym.valid) begin
			mark_q  <= mark_d & TickMask;
			space_q <= space_d & TickMask;
			last_q  <= sym.last;
		end
	end

	assign out_valid   = valid_q;
	assign mark_ticks  = mark_q;
	assign space_ticks = space_q;
	assign last_of_run = last_q;

endmodule

### hw/rtl/pulse_width_byte_serializer_core.sv
// The first pulse pair of an item is registered in the sequencer state and then in the output register.
// Throughput: one pair per cycle from a single pair sequencer while the output is not stalled; an item yields
//   bits + parity(0/1) + (first: sync+1) + (last: 2) pairs, 1 to 44 in all.
// A new item is taken the cycle after the last pair enters the output register.
// Reset: configuration returns to its defaults, sequencer goes idle, output empties.
`include "pulse_width_byte_serializer_core_defines.svh"

module pulse_width_byte_serializer_core #(
	parameter int TICK_WIDTH = pwbs_pkg::TICK_WIDTH_DEF,
	parameter int MAX_SYNC   = pwbs_pkg::MAX_SYNC_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] mark_ticks,
	output logic [15:0] space_ticks,
	output logic        last_of_run
);

	pwbs_pkg::cfg_t cfg_q;
	pwbs_pkg::sym_t sym;
	logic           busy;
	logic           step;
	logic           start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_count    <= pwbs_pkg::RstSyncCount;
			cfg_q.zero_mark     <= pwbs_pkg::RstZeroMark;
			cfg_q.zero_space    <= pwbs_pkg::RstZeroSpace;
			cfg_q.one_mark      <= pwbs_pkg::RstOneMark;
			cfg_q.one_space     <= pwbs_pkg::RstOneSpace;
			cfg_q.idle_space    <= pwbs_pkg::RstIdleSpace;
			cfg_q.bits_per_char <= pwbs_pkg::RstBitsPerChar;
			cfg_q.frame_mode    <= pwbs_pkg::RstFrameMode;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				pwbs_pkg::CfgSyncCount:   cfg_q.sync_count    <= cfg_wdata[5:0];
				pwbs_pkg::CfgZeroMark:    cfg_q.zero_mark     <= cfg_wdata;
				pwbs_pkg::CfgZeroSpace:   cfg_q.zero_space    <= cfg_wdata;
				pwbs_pkg::CfgOneMark:     cfg_q.one_mark      <= cfg_wdata;
				pwbs_pkg::CfgOneSpace:    cfg_q.one_space     <= cfg_wdata;
				pwbs_pkg::CfgIdleSpace:   cfg_q.idle_space    <= cfg_wdata;
				pwbs_pkg::CfgBitsPerChar: cfg_q.bits_per_char <= cfg_wdata[3:0];
				pwbs_pkg::CfgFrameMode:   cfg_q.frame_mode    <= cfg_wdata[3:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = busy;
	assign start    = in_valid && !in_stall;

	pwbs_seq #(
		.MAX_SYNC(MAX_SYNC)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.cfg        (cfg_q),
		.step       (step),
		.busy       (busy),
		.sym        (sym)
	);

	pwbs_out #(
		.TICK_WIDTH(TICK_WIDTH)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.sym         (sym),
		.cfg         (cfg_q),
		.out_stall   (out_stall),
		.step        (step),
		.out_valid   (out_valid),
		.mark_ticks  (mark_ticks),
		.space_ticks (space_ticks),
		.last_of_run (last_of_run)
	);

	// every item yields at least one pair, so the sequencer must be busy next cycle
	`PWBS_ASSERT(a_accept_busy, clk, arst_n, (in_valid && !in_stall) |=> in_stall)
	// a pair that is not the end of its run means more pairs are still to come
	`PWBS_ASSERT_IMPL(a_mid_run_busy, out_valid && !out_stall && !last_of_run, in_stall)

endmodule
